// ===== rtl/sdo_prt_pkg.sv =====
package sdo_prt_pkg;

    // table geometry
    localparam int PENDING_DEPTH = 16;
    localparam int PTR_W         = $clog2(PENDING_DEPTH);
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);

    // eviction report cap per tick
    localparam int MAX_RESULTS   = 16;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int ID_W          = 11;
    localparam int INDEX_W       = 16;
    localparam int SUB_W         = 8;
    localparam int CMD_W         = 8;
    localparam int DATA_W        = 32;
    localparam int AGE_W         = 5;
    localparam int LIMIT_W       = 4;

    localparam logic [AGE_W-1:0]   AGE_MAX       = 5'd31;
    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 4'd3;

    // response identifier window and request/response offset
    localparam logic [ID_W-1:0]  RESP_ID_LO   = 11'h580;
    localparam logic [ID_W-1:0]  RESP_ID_HI   = 11'h600;
    localparam logic [ID_W-1:0]  ID_OFFSET    = 11'h080;

    // response command bytes
    localparam logic [CMD_W-1:0] CMD_WRITE_ACK = 8'h60;
    localparam logic [CMD_W-1:0] CMD_READ_LO   = 8'h40;

    typedef enum logic [1:0] {
        KIND_ISSUE    = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_TICK     = 2'd2
    } kind_e;

    typedef enum logic [2:0] {
        ST_ISSUED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_WR_ACK    = 3'd2,
        ST_READ      = 3'd3,
        ST_ABORT     = 3'd4,
        ST_UNMATCHED = 3'd5,
        ST_TIMEOUT   = 3'd6,
        ST_IGNORED   = 3'd7
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP_SCAN,
        S_TICK_COUNT,
        S_TICK_SWEEP,
        S_EMIT
    } state_e;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [INDEX_W-1:0] index;
        logic [SUB_W-1:0]   subindex;
        logic [AGE_W-1:0]   age;
    } slot_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [INDEX_W-1:0] index;
        logic [SUB_W-1:0]   subindex;
    } key_t;

    typedef struct packed {
        logic             match;
        logic             expire;
        logic [AGE_W-1:0] aged;
    } eval_t;

endpackage

// ===== rtl/sdo_pending_request_tracker.sv =====
// SDO pending request tracker. Keeps up to PENDING_DEPTH outstanding expedited
// SDO requests in arrival order. tuser selects the beat kind: issue stores the
// request and returns one result with the packed 8-byte request payload (or a
// table-full flag); response, with a frame id strictly inside the response
// window (else ignored), matches the oldest entry whose id, less 0x80, equals
// the frame id, with equal index and subindex, reports write ack, read data or
// abort and drops that entry, or reports unmatched; tick ages all entries and
// reports every entry past timeout_limit as timed out, oldest first, at most 16
// per tick. Timing: one slot evaluator visits one table entry per clock, except
// while the compacting pass of a tick waits on m_tready to report an eviction.
// A tick beat makes a counting pass to find the last eviction, then a compacting
// pass. s_tready is low while a beat is being worked on. The output register
// lets the next beat be accepted while a result waits. No clearing pass after
// reset: slots above the fill count are never read.
module sdo_pending_request_tracker (
    input  logic         aclk,
    input  logic         aresetn,
    // timeout_limit register
    input  logic         cfg_we,
    input  logic [3:0]   cfg_wdata,     // timeout_limit
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,       // frame_id, command_byte, object_index,
                                        // subindex, data_word, zero pad
    input  logic [1:0]   s_tuser,       // kind
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,       // entry_id, entry_index, entry_subindex,
                                        // request_payload, read_value, zero pad
    output logic [2:0]   m_tuser,       // status
    output logic         m_tlast
);
    import sdo_prt_pkg::*;

    // input field unpacking
    logic [ID_W-1:0]    s_frame_id;
    logic [CMD_W-1:0]   s_cmd;
    logic [INDEX_W-1:0] s_index;
    logic [SUB_W-1:0]   s_sub;
    logic [DATA_W-1:0]  s_data;
    kind_e              s_kind;

    assign s_frame_id = s_tdata[10:0];
    assign s_cmd      = s_tdata[18:11];
    assign s_index    = s_tdata[34:19];
    assign s_sub      = s_tdata[42:35];
    assign s_data     = s_tdata[74:43];
    assign s_kind     = kind_e'(s_tuser);

    // control state
    state_e             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_W-1:0]   ev_total_reg, ev_total_next;
    logic [RES_W-1:0]   ev_done_reg, ev_done_next;
    logic               found_reg, found_next;
    status_e            status_reg, status_next;
    logic [LIMIT_W-1:0] limit_reg;

    // latched beat fields
    logic [ID_W-1:0]    fid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [SUB_W-1:0]   sub_reg;
    logic [DATA_W-1:0]  data_reg;

    // pending table, one write port, one read port at the sweep pointer
    slot_t              table_reg [PENDING_DEPTH];
    logic               tbl_we;
    logic [PTR_W-1:0]   tbl_waddr;
    slot_t              tbl_wdata;
    slot_t              cur_slot;

    // output register
    logic               m_tvalid_reg;
    logic               out_load;
    status_e            out_status_next;
    logic [ID_W-1:0]    out_id_next,   out_id_reg;
    logic [INDEX_W-1:0] out_index_next, out_index_reg;
    logic [SUB_W-1:0]   out_sub_next,  out_sub_reg;
    logic [63:0]        out_payload_next, out_payload_reg;
    logic [DATA_W-1:0]  out_read_next, out_read_reg;
    logic               out_last_next, out_last_reg;
    status_e            out_status_reg;
    logic               out_free;

    key_t               resp_key;
    eval_t              ev;
    logic               in_accept;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cur_slot  = table_reg[rd_ptr_reg[PTR_W-1:0]];

    // a response frame with id n answers a request sent with id n + 0x80
    assign resp_key.id       = fid_reg + ID_OFFSET;
    assign resp_key.index    = index_reg;
    assign resp_key.subindex = sub_reg;

    sdo_prt_slot_eval u_eval (
        .slot   (cur_slot),
        .key    (resp_key),
        .limit  (limit_reg),
        .result (ev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            ev_total_reg <= '0;
            ev_done_reg  <= '0;
            found_reg    <= 1'b0;
            status_reg   <= ST_ISSUED;
            limit_reg    <= TIMEOUT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            ev_total_reg <= ev_total_next;
            ev_done_reg  <= ev_done_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            fid_reg   <= s_frame_id;
            cmd_reg   <= s_cmd;
            index_reg <= s_index;
            sub_reg   <= s_sub;
            data_reg  <= s_data;
        end
        if (tbl_we) begin
            table_reg[tbl_waddr] <= tbl_wdata;
        end
        if (out_load) begin
            out_status_reg  <= out_status_next;
            out_id_reg      <= out_id_next;
            out_index_reg   <= out_index_next;
            out_sub_reg     <= out_sub_next;
            out_payload_reg <= out_payload_next;
            out_read_reg    <= out_read_next;
            out_last_reg    <= out_last_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        ev_total_next    = ev_total_reg;
        ev_done_next     = ev_done_reg;
        found_next       = found_reg;
        status_next      = status_reg;
        tbl_we           = 1'b0;
        tbl_waddr        = wr_ptr_reg[PTR_W-1:0];
        tbl_wdata        = cur_slot;
        out_load         = 1'b0;
        out_status_next  = status_reg;
        out_id_next      = '0;
        out_index_next   = '0;
        out_sub_next     = '0;
        out_payload_next = '0;
        out_read_next    = '0;
        out_last_next    = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (s_kind)
                        KIND_ISSUE: begin
                            if (count_reg < CNT_W'(PENDING_DEPTH)) begin
                                // append at the tail
                                tbl_we             = 1'b1;
                                tbl_waddr          = count_reg[PTR_W-1:0];
                                tbl_wdata.id       = s_frame_id;
                                tbl_wdata.index    = s_index;
                                tbl_wdata.subindex = s_sub;
                                tbl_wdata.age      = '0;
                                count_next         = CNT_W'(count_reg + 1'b1);
                                status_next        = ST_ISSUED;
                            end else begin
                                status_next = ST_FULL;
                            end
                            state_next = S_EMIT;
                        end
                        KIND_RESPONSE: begin
                            if (s_frame_id > RESP_ID_LO && s_frame_id < RESP_ID_HI) begin
                                rd_ptr_next = '0;
                                wr_ptr_next = '0;
                                found_next  = 1'b0;
                                state_next  = S_RESP_SCAN;
                            end else begin
                                status_next = ST_IGNORED;
                                state_next  = S_EMIT;
                            end
                        end
                        KIND_TICK: begin
                            // empty table: nothing to age, no result
                            if (count_reg != '0) begin
                                rd_ptr_next   = '0;
                                ev_total_next = '0;
                                state_next    = S_TICK_COUNT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RESP_SCAN: begin
                if (rd_ptr_reg < count_reg) begin
                    if (!found_reg && ev.match) begin
                        // first match is dropped from the table
                        found_next = 1'b1;
                    end else begin
                        tbl_we      = 1'b1;
                        wr_ptr_next = CNT_W'(wr_ptr_reg + 1'b1);
                    end
                    rd_ptr_next = CNT_W'(rd_ptr_reg + 1'b1);
                end else begin
                    count_next = wr_ptr_reg;
                    if (!found_reg) begin
                        status_next = ST_UNMATCHED;
                    end else if (cmd_reg == CMD_WRITE_ACK) begin
                        status_next = ST_WR_ACK;
                    end else if (cmd_reg >= CMD_READ_LO && cmd_reg < CMD_WRITE_ACK) begin
                        status_next = ST_READ;
                    end else begin
                        status_next = ST_ABORT;
                    end
                    state_next = S_EMIT;
                end
            end

            S_TICK_COUNT: begin
                // first pass: count evictions so the last one can be flagged
                if (rd_ptr_reg < count_reg) begin
                    if (ev.expire && ev_total_reg < RES_W'(MAX_RESULTS)) begin
                        ev_total_next = RES_W'(ev_total_reg + 1'b1);
                    end
                    rd_ptr_next = CNT_W'(rd_ptr_reg + 1'b1);
                end else begin
                    rd_ptr_next  = '0;
                    wr_ptr_next  = '0;
                    ev_done_next = '0;
                    state_next   = S_TICK_SWEEP;
                end
            end

            S_TICK_SWEEP: begin
                // second pass: report evictions, write back aged survivors
                if (rd_ptr_reg < count_reg) begin
                    if (ev.expire && ev_done_reg < RES_W'(MAX_RESULTS)) begin
                        if (out_free) begin
                            out_load        = 1'b1;
                            out_status_next = ST_TIMEOUT;
                            out_id_next     = cur_slot.id;
                            out_index_next  = cur_slot.index;
                            out_sub_next    = cur_slot.subindex;
                            out_last_next   = (RES_W'(ev_done_reg + 1'b1) == ev_total_reg);
                            ev_done_next    = RES_W'(ev_done_reg + 1'b1);
                            rd_ptr_next     = CNT_W'(rd_ptr_reg + 1'b1);
                        end
                    end else begin
                        tbl_we        = 1'b1;
                        tbl_wdata.age = ev.aged;
                        wr_ptr_next   = CNT_W'(wr_ptr_reg + 1'b1);
                        rd_ptr_next   = CNT_W'(rd_ptr_reg + 1'b1);
                    end
                end else begin
                    count_next = wr_ptr_reg;
                    state_next = S_IDLE;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    case (status_reg) inside
                        ST_ISSUED, ST_FULL: begin
                            out_id_next    = fid_reg;
                            out_index_next = index_reg;
                            out_sub_next   = sub_reg;
                        end
                        ST_WR_ACK, ST_READ, ST_ABORT: begin
                            out_id_next    = resp_key.id;
                            out_index_next = index_reg;
                            out_sub_next   = sub_reg;
                        end
                        default: begin
                        end
                    endcase
                    if (status_reg == ST_ISSUED) begin
                        out_payload_next = {data_reg, sub_reg, index_reg, cmd_reg};
                    end
                    if (status_reg == ST_READ) begin
                        out_read_next = data_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_read_reg, out_payload_reg, out_sub_reg,
                       out_index_reg, out_id_reg};

endmodule

// ===== rtl/sdo_prt_slot_eval.sv =====
// evaluates one table slot per cycle: response match, aging and expiry
module sdo_prt_slot_eval (
    input  sdo_prt_pkg::slot_t                      slot,
    input  sdo_prt_pkg::key_t                       key,
    input  logic [sdo_prt_pkg::LIMIT_W-1:0]         limit,
    output sdo_prt_pkg::eval_t                      result
);
    import sdo_prt_pkg::*;

    logic [AGE_W-1:0] aged;

    // saturating age increment
    assign aged = (slot.age == AGE_MAX) ? slot.age : AGE_W'(slot.age + 1'b1);

    assign result.aged   = aged;
    assign result.expire = aged > {{(AGE_W - LIMIT_W){1'b0}}, limit};
    assign result.match  = (slot.id == key.id) && (slot.index == key.index)
                           && (slot.subindex == key.subindex);

endmodule
